@@ rtl/core/em2iso_pkg.sv @@
// shared types, constants and helper functions for the epoch-millis to ISO 8601 converter
package em2iso_pkg;

    // field widths
    localparam int MILLIS_W = 64;
    localparam int CHAR_W   = 8;

    // internal value widths
    localparam int MS_W    = 48;
    localparam int DIV_W   = 50;
    localparam int DAYS_W  = 22;
    localparam int TOD_W   = 27;
    localparam int DATE_W  = 22;
    localparam int YEAR_W  = 14;
    localparam int STEP_W  = 4;
    localparam int DIGIT_W = 4;

    // first rejected instant, 10000-01-01T00:00:00.000Z, in milliseconds
    localparam logic [MILLIS_W-2:0] MS_LIMIT = 63'd253402300800000;

    // days from 0000-03-01 to 1970-01-01
    localparam logic [DATE_W-1:0] DAYS_TO_EPOCH = 22'd719468;

    // sequencer lengths
    localparam int DIV_STEPS = 7;
    localparam int TOD_STEPS = 9;

    // calendar sequencer steps with special meaning
    localparam logic [STEP_W-1:0] CAL_ZSTEP = 4'd0;
    localparam logic [STEP_W-1:0] CAL_MONTH = 4'd7;
    localparam logic [STEP_W-1:0] CAL_YTHOU = 4'd8;
    localparam logic [STEP_W-1:0] CAL_LAST  = 4'd10;

    // text layout
    localparam int TEXT_LEN = 24;
    localparam int POS_W    = 5;

    // characters
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;

    // request queue
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    typedef logic [DIGIT_W-1:0] t_digit;

    // one request as it travels through the queue
    typedef struct packed {
        logic            err;
        logic [MS_W-1:0] ms;
    } t_job;

    // fully converted request, all fields as decimal digits, most significant first
    typedef struct packed {
        logic                       err;
        t_digit [3:0]               year;
        t_digit [1:0]               month;
        t_digit [1:0]               day;
        t_digit [TOD_STEPS-1:0]     tod;
    } t_rec;

    // result of one digit extraction step
    typedef struct packed {
        t_digit           digit;
        logic [DIV_W-1:0] prod;
    } t_dig;

    // calendar step weights: day weight, digit cap, years per unit
    typedef struct packed {
        logic [DATE_W-1:0] w;
        t_digit            maxd;
        logic [11:0]       yw;
    } t_calw;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_DIV,
        CS_CAL,
        CS_DONE
    } t_cstate;

    // largest digit d <= maxd with d*w <= rem, and the product d*w
    function automatic t_dig dig_sel(input logic [DIV_W-1:0] rem,
                                     input logic [DIV_W-1:0] w,
                                     input t_digit           maxd);
        t_dig             r;
        logic [DIV_W-1:0] m;
        r.digit = '0;
        r.prod  = '0;
        for (int j = 1; j <= 9; j++) begin
            m = w * DIV_W'(j);
            if ((DIGIT_W'(j) <= maxd) && (rem >= m)) begin
                r.digit = DIGIT_W'(j);
                r.prod  = m;
            end
        end
        return r;
    endfunction

    // decimal weights of the day count, in milliseconds
    function automatic logic [DIV_W-1:0] day_weight(input logic [STEP_W-1:0] s);
        logic [DIV_W-1:0] w;
        case (s)
            4'd0:    w = 50'd86400000000000;
            4'd1:    w = 50'd8640000000000;
            4'd2:    w = 50'd864000000000;
            4'd3:    w = 50'd86400000000;
            4'd4:    w = 50'd8640000000;
            4'd5:    w = 50'd864000000;
            4'd6:    w = 50'd86400000;
            default: w = '0;
        endcase
        return w;
    endfunction

    // mixed-radix weights of HH MM SS mmm, in milliseconds
    function automatic logic [TOD_W-1:0] tod_weight(input logic [STEP_W-1:0] s);
        logic [TOD_W-1:0] w;
        case (s)
            4'd0:    w = 27'd36000000;
            4'd1:    w = 27'd3600000;
            4'd2:    w = 27'd600000;
            4'd3:    w = 27'd60000;
            4'd4:    w = 27'd10000;
            4'd5:    w = 27'd1000;
            4'd6:    w = 27'd100;
            4'd7:    w = 27'd10;
            4'd8:    w = 27'd1;
            default: w = '0;
        endcase
        return w;
    endfunction

    // eras, centuries, four-year blocks and years, then the year digits
    function automatic t_calw cal_tab(input logic [STEP_W-1:0] s);
        t_calw c;
        case (s)
            4'd1:    c = '{w: 22'd1460970, maxd: 4'd9, yw: 12'd4000};
            4'd2:    c = '{w: 22'd146097,  maxd: 4'd9, yw: 12'd400};
            4'd3:    c = '{w: 22'd36524,   maxd: 4'd3, yw: 12'd100};
            4'd4:    c = '{w: 22'd14610,   maxd: 4'd9, yw: 12'd40};
            4'd5:    c = '{w: 22'd1461,    maxd: 4'd9, yw: 12'd4};
            4'd6:    c = '{w: 22'd365,     maxd: 4'd3, yw: 12'd1};
            4'd8:    c = '{w: 22'd1000,    maxd: 4'd9, yw: 12'd0};
            4'd9:    c = '{w: 22'd100,     maxd: 4'd9, yw: 12'd0};
            4'd10:   c = '{w: 22'd10,      maxd: 4'd9, yw: 12'd0};
            default: c = '{w: 22'd0,       maxd: 4'd0, yw: 12'd0};
        endcase
        return c;
    endfunction

    // first day of each month, counted from March 1
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // two decimal digits of a value below 32
    function automatic logic [7:0] bcd2(input logic [4:0] v);
        logic [7:0] r;
        if (v >= 5'd30) begin
            r = {4'd3, 4'(v - 5'd30)};
        end else if (v >= 5'd20) begin
            r = {4'd2, 4'(v - 5'd20)};
        end else if (v >= 5'd10) begin
            r = {4'd1, 4'(v - 5'd10)};
        end else begin
            r = {4'd0, v[3:0]};
        end
        return r;
    endfunction

endpackage

@@ rtl/core/em2iso_front.sv @@
// front end: takes requests and classifies them as convertible or rejected
module em2iso_front (
    input  logic                               i_valid,
    input  logic [em2iso_pkg::MILLIS_W-1:0]    i_epoch_millis,
    input  logic                               i_q_full,
    output logic                               o_push,
    output em2iso_pkg::t_job                   o_job
);

    // push whenever the queue has room
    assign o_push = i_valid && !i_q_full;

    // negative counts and years past 9999 are rejected
    always_comb begin
        o_job.err = i_epoch_millis[em2iso_pkg::MILLIS_W-1]
                 || (i_epoch_millis[em2iso_pkg::MILLIS_W-2:0] >= em2iso_pkg::MS_LIMIT);
        o_job.ms  = i_epoch_millis[em2iso_pkg::MS_W-1:0];
    end

endmodule

@@ rtl/core/em2iso_queue.sv @@
// two-entry request queue between the front end and the converter
module em2iso_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  em2iso_pkg::t_job     i_data,
    input  logic                 i_pop,
    output logic                 o_valid,
    output logic                 o_full,
    output em2iso_pkg::t_job     o_data
);

    em2iso_pkg::t_job                r_mem [em2iso_pkg::QDEPTH];
    logic [em2iso_pkg::QAW-1:0]      r_wr;
    logic [em2iso_pkg::QAW-1:0]      r_rd;
    logic [em2iso_pkg::QAW:0]        r_count;
    logic [em2iso_pkg::QAW-1:0]      n_wr;
    logic [em2iso_pkg::QAW-1:0]      n_rd;
    logic [em2iso_pkg::QAW:0]        n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (em2iso_pkg::QAW + 1)'(em2iso_pkg::QDEPTH));
    assign o_data  = r_mem[r_rd];

    // pointer and fill count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ rtl/core/em2iso_conv.sv @@
// converter: splits milliseconds into days and time of day, then into decimal date fields
module em2iso_conv (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  em2iso_pkg::t_job     i_q_data,
    output logic                 o_q_pop,
    output logic                 o_rec_valid,
    output em2iso_pkg::t_rec     o_rec,
    input  logic                 i_rec_take
);

    em2iso_pkg::t_cstate                 r_state, n_state;
    logic [em2iso_pkg::STEP_W-1:0]       r_step, n_step;
    logic                                r_err, n_err;
    logic [em2iso_pkg::MS_W-1:0]         r_ms, n_ms;
    logic [em2iso_pkg::DAYS_W-1:0]       r_days, n_days;
    logic [em2iso_pkg::TOD_W-1:0]        r_tod, n_tod;
    logic [em2iso_pkg::DATE_W-1:0]       r_drem, n_drem;
    logic [em2iso_pkg::YEAR_W-1:0]       r_year, n_year;
    logic [3:0]                          r_month, n_month;
    logic [4:0]                          r_day, n_day;
    em2iso_pkg::t_digit [3:0]            r_ydig, n_ydig;
    em2iso_pkg::t_digit [1:0]            r_mdig, n_mdig;
    em2iso_pkg::t_digit [1:0]            r_ddig, n_ddig;
    em2iso_pkg::t_digit [em2iso_pkg::TOD_STEPS-1:0] r_tdig, n_tdig;

    em2iso_pkg::t_dig                    dd;
    em2iso_pkg::t_dig                    td;
    em2iso_pkg::t_dig                    cd;
    em2iso_pkg::t_calw                   cw;
    logic [8:0]                          doy;
    logic [3:0]                          mp;
    logic [3:0]                          month;
    logic [em2iso_pkg::YEAR_W-1:0]       year_adj;

    // digit extraction units for the day count, time of day and calendar
    always_comb begin
        cw = em2iso_pkg::cal_tab(r_step);
        dd = em2iso_pkg::dig_sel(em2iso_pkg::DIV_W'(r_ms),
                                 em2iso_pkg::day_weight(r_step), 4'd9);
        td = em2iso_pkg::dig_sel(em2iso_pkg::DIV_W'(r_tod),
                                 em2iso_pkg::DIV_W'(em2iso_pkg::tod_weight(r_step)), 4'd9);
        cd = em2iso_pkg::dig_sel(em2iso_pkg::DIV_W'(r_drem),
                                 em2iso_pkg::DIV_W'(cw.w), cw.maxd);
    end

    // month and day from the day of a March-based year
    always_comb begin
        doy = r_drem[8:0];
        mp  = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (doy >= em2iso_pkg::month_start(4'(k))) begin
                mp = 4'(k);
            end
        end
        month    = (mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9);
        year_adj = r_year + ((month <= 4'd2) ? em2iso_pkg::YEAR_W'(1) : '0);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_err   = r_err;
        n_ms    = r_ms;
        n_days  = r_days;
        n_tod   = r_tod;
        n_drem  = r_drem;
        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        n_ydig  = r_ydig;
        n_mdig  = r_mdig;
        n_ddig  = r_ddig;
        n_tdig  = r_tdig;
        o_q_pop = 1'b0;
        case (r_state)
            em2iso_pkg::CS_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_err   = i_q_data.err;
                    n_ms    = i_q_data.ms;
                    n_days  = '0;
                    n_year  = '0;
                    n_step  = '0;
                    n_state = i_q_data.err ? em2iso_pkg::CS_DONE : em2iso_pkg::CS_DIV;
                end
            end
            em2iso_pkg::CS_DIV: begin
                // one decimal digit of the day count per cycle
                n_ms   = r_ms - dd.prod[em2iso_pkg::MS_W-1:0];
                n_days = em2iso_pkg::DAYS_W'({r_days, 3'b000} + {2'b00, r_days, 1'b0}
                                             + {21'd0, dd.digit});
                if (r_step == em2iso_pkg::STEP_W'(em2iso_pkg::DIV_STEPS - 1)) begin
                    n_tod   = em2iso_pkg::TOD_W'(n_ms);
                    n_step  = '0;
                    n_state = em2iso_pkg::CS_CAL;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            em2iso_pkg::CS_CAL: begin
                // time of day digits run beside the calendar steps
                if (r_step < em2iso_pkg::STEP_W'(em2iso_pkg::TOD_STEPS)) begin
                    n_tdig[r_step] = td.digit;
                    n_tod          = r_tod - td.prod[em2iso_pkg::TOD_W-1:0];
                end
                // calendar
                if (r_step == em2iso_pkg::CAL_ZSTEP) begin
                    n_drem = em2iso_pkg::DATE_W'(r_days) + em2iso_pkg::DAYS_TO_EPOCH;
                end else if (r_step == em2iso_pkg::CAL_MONTH) begin
                    n_month = month;
                    n_day   = 5'(doy - em2iso_pkg::month_start(mp) + 9'd1);
                    n_drem  = em2iso_pkg::DATE_W'(year_adj);
                end else begin
                    n_drem = r_drem - cd.prod[em2iso_pkg::DATE_W-1:0];
                    if (r_step < em2iso_pkg::CAL_MONTH) begin
                        n_year = r_year + em2iso_pkg::YEAR_W'(16'(cd.digit) * 16'(cw.yw));
                    end else begin
                        n_ydig[2'(r_step - em2iso_pkg::CAL_YTHOU)] = cd.digit;
                    end
                end
                if (r_step == em2iso_pkg::CAL_YTHOU) begin
                    {n_mdig[0], n_mdig[1]} = em2iso_pkg::bcd2({1'b0, r_month});
                    {n_ddig[0], n_ddig[1]} = em2iso_pkg::bcd2(r_day);
                end
                if (r_step == em2iso_pkg::CAL_LAST) begin
                    n_ydig[3] = 4'(r_drem - cd.prod[em2iso_pkg::DATE_W-1:0]);
                    n_state   = em2iso_pkg::CS_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            em2iso_pkg::CS_DONE: begin
                if (i_rec_take) begin
                    n_state = em2iso_pkg::CS_IDLE;
                end
            end
            default: begin
                n_state = em2iso_pkg::CS_IDLE;
            end
        endcase
    end

    // finished record toward the emitter
    assign o_rec_valid = (r_state == em2iso_pkg::CS_DONE);
    always_comb begin
        o_rec.err   = r_err;
        o_rec.year  = r_ydig;
        o_rec.month = r_mdig;
        o_rec.day   = r_ddig;
        o_rec.tod   = r_tdig;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= em2iso_pkg::CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_err   <= n_err;
        r_ms    <= n_ms;
        r_days  <= n_days;
        r_tod   <= n_tod;
        r_drem  <= n_drem;
        r_year  <= n_year;
        r_month <= n_month;
        r_day   <= n_day;
        r_ydig  <= n_ydig;
        r_mdig  <= n_mdig;
        r_ddig  <= n_ddig;
        r_tdig  <= n_tdig;
    end

endmodule

@@ rtl/core/em2iso_emit.sv @@
// emitter: walks a converted record out as text, one character per cycle while the output is not stalled
module em2iso_emit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_rec_valid,
    input  em2iso_pkg::t_rec                     i_rec,
    output logic                                 o_rec_take,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [em2iso_pkg::CHAR_W-1:0]        o_char_code,
    output logic                                 o_is_last,
    output logic                                 o_error
);

    logic                                r_busy, n_busy;
    logic [em2iso_pkg::POS_W-1:0]        r_pos, n_pos;
    em2iso_pkg::t_rec                    r_rec, n_rec;
    logic                                r_valid, n_valid;
    logic [em2iso_pkg::CHAR_W-1:0]       r_char, n_char;
    logic                                r_last, n_last;
    logic                                r_err, n_err;
    logic                                adv;
    logic                                cur_last;
    logic [em2iso_pkg::CHAR_W-1:0]       cur_char;

    // ASCII character of a decimal digit
    function automatic logic [em2iso_pkg::CHAR_W-1:0] dchar(input em2iso_pkg::t_digit d);
        return em2iso_pkg::CH_ZERO | {4'h0, d};
    endfunction

    always_comb begin
        if (r_rec.err) begin
            cur_char = em2iso_pkg::CH_NUL;
        end else begin
            case (r_pos)
                5'd0:    cur_char = dchar(r_rec.year[0]);
                5'd1:    cur_char = dchar(r_rec.year[1]);
                5'd2:    cur_char = dchar(r_rec.year[2]);
                5'd3:    cur_char = dchar(r_rec.year[3]);
                5'd4:    cur_char = em2iso_pkg::CH_DASH;
                5'd5:    cur_char = dchar(r_rec.month[0]);
                5'd6:    cur_char = dchar(r_rec.month[1]);
                5'd7:    cur_char = em2iso_pkg::CH_DASH;
                5'd8:    cur_char = dchar(r_rec.day[0]);
                5'd9:    cur_char = dchar(r_rec.day[1]);
                5'd10:   cur_char = em2iso_pkg::CH_T;
                5'd11:   cur_char = dchar(r_rec.tod[0]);
                5'd12:   cur_char = dchar(r_rec.tod[1]);
                5'd13:   cur_char = em2iso_pkg::CH_COLON;
                5'd14:   cur_char = dchar(r_rec.tod[2]);
                5'd15:   cur_char = dchar(r_rec.tod[3]);
                5'd16:   cur_char = em2iso_pkg::CH_COLON;
                5'd17:   cur_char = dchar(r_rec.tod[4]);
                5'd18:   cur_char = dchar(r_rec.tod[5]);
                5'd19:   cur_char = em2iso_pkg::CH_DOT;
                5'd20:   cur_char = dchar(r_rec.tod[6]);
                5'd21:   cur_char = dchar(r_rec.tod[7]);
                5'd22:   cur_char = dchar(r_rec.tod[8]);
                default: cur_char = em2iso_pkg::CH_Z;
            endcase
        end
    end

    // the error result and the closing 'Z' end a request
    assign cur_last = r_rec.err
                   || (r_pos == em2iso_pkg::POS_W'(em2iso_pkg::TEXT_LEN - 1));

    // output slot is free when empty or being taken
    assign adv        = !r_valid || !i_stall;
    assign o_rec_take = i_rec_valid && (!r_busy || (adv && cur_last));

    always_comb begin
        n_busy  = r_busy;
        n_pos   = r_pos;
        n_rec   = r_rec;
        n_valid = r_valid;
        n_char  = r_char;
        n_last  = r_last;
        n_err   = r_err;
        if (adv) begin
            n_valid = r_busy;
            if (r_busy) begin
                n_char = cur_char;
                n_last = cur_last;
                n_err  = r_rec.err;
                n_pos  = r_pos + 1'b1;
                if (cur_last) begin
                    n_busy = 1'b0;
                end
            end
        end
        // load the next record right behind the last character
        if (o_rec_take) begin
            n_rec  = i_rec;
            n_busy = 1'b1;
            n_pos  = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_rec  <= n_rec;
        r_char <= n_char;
        r_last <= n_last;
        r_err  <= n_err;
    end

    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_is_last   = r_last;
    assign o_error     = r_err;

endmodule

@@ rtl/core/epoch_millis_to_iso8601_text.sv @@
// top level: Unix milliseconds in, ISO 8601 UTC text out one character at a time
//
//   channel   direction  valid    stall     payload
//   request   in         i_valid  o_stall   i_epoch_millis
//   text      out        o_valid  i_stall   o_char_code, o_is_last, o_error
//
// A good request gives 24 characters, one per cycle unless the text side stalls; the
// converter (7 day-count digit steps, 11 calendar and time-of-day steps, queue pop and
// hand-off) runs while the previous text drains.
// A rejected request gives one result; the converter skips the conversion steps for it.
// Reset is synchronous, active low, and empties the queue and the output register.
// A stall on the text side holds the character; the queue keeps taking requests until full.
module epoch_millis_to_iso8601_text (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [em2iso_pkg::MILLIS_W-1:0]      i_epoch_millis,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [em2iso_pkg::CHAR_W-1:0]        o_char_code,
    output logic                                 o_is_last,
    output logic                                 o_error
);

    logic                q_full;
    logic                q_push;
    em2iso_pkg::t_job    q_in;
    logic                q_valid;
    logic                q_pop;
    em2iso_pkg::t_job    q_out;
    logic                rec_valid;
    logic                rec_take;
    em2iso_pkg::t_rec    rec;

    assign o_stall = q_full;

    // request classification
    em2iso_front u_front (
        .i_valid        (i_valid),
        .i_epoch_millis (i_epoch_millis),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_job          (q_in)
    );

    // request queue
    em2iso_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_out)
    );

    // date and time conversion
    em2iso_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_out),
        .o_q_pop     (q_pop),
        .o_rec_valid (rec_valid),
        .o_rec       (rec),
        .i_rec_take  (rec_take)
    );

    // text output
    em2iso_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (rec_valid),
        .i_rec       (rec),
        .o_rec_take  (rec_take),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_is_last   (o_is_last),
        .o_error     (o_error)
    );

endmodule

@@ rtl/core/em2iso_checker.sv @@
// port-level checks on the text output of the converter, bound to the top level
module em2iso_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 o_valid,
    input  logic                                 i_stall,
    input  logic [em2iso_pkg::CHAR_W-1:0]        o_char_code,
    input  logic                                 o_is_last,
    input  logic                                 o_error
);

    // a stalled character stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_char_code)
                               && $stable(o_is_last) && $stable(o_error))
        else $error("stalled character changed");

    // a rejected request is a single closing result with no character
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_is_last && (o_char_code == em2iso_pkg::CH_NUL))
        else $error("error result not closing or not empty");

    // good text always closes on the zone letter
    a_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_error && o_is_last |-> (o_char_code == em2iso_pkg::CH_Z))
        else $error("text does not close on zone letter");

    // reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind epoch_millis_to_iso8601_text em2iso_checker u_checker (.*);

@@ test/epoch_millis_to_iso8601_text_checker.sv @@
// checker for the epoch-millis to ISO 8601 converter: timestamp text predictor and comparator
`timescale 1ns / 100ps

module epoch_millis_to_iso8601_text_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_stall,
    input  logic [em2iso_pkg::MILLIS_W-1:0] i_req_millis,
    input  logic                            i_text_valid,
    input  logic                            i_text_stall,
    input  logic [em2iso_pkg::CHAR_W-1:0]   i_char_code,
    input  logic                            i_is_last,
    input  logic                            i_error,
    output int                              o_fail_count,
    output int                              o_outstanding
);
    import em2iso_pkg::*;

    localparam longint unsigned LAST_YEAR = 64'd9999;

    // one character of the timestamp text as the block should send it
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
        logic              error;
    } text_char_t;

    text_char_t expected_text[$];

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    // append one character to the tail of the expected stream
    function automatic void add_expected(input text_char_t c);
        expected_text.insert(expected_text.size(), c);
    endfunction

    // ascii digit of v at the given decimal place
    function automatic logic [CHAR_W-1:0] dec_digit(input longint unsigned v,
                                                    input longint unsigned place);
        return CH_ZERO + CHAR_W'((v / place) % 64'd10);
    endfunction

    // civil date and time of a millisecond count, queued as text characters
    task automatic predict_timestamp_text(input logic [MILLIS_W-1:0] millis);
        longint unsigned secs, ms, days, sod, z, era, doe, yoe, year, doy, mp, day, month;
        logic [CHAR_W-1:0] text [TEXT_LEN];
        // negative count is rejected outright
        if (millis[MILLIS_W-1]) begin
            add_expected('{char_code: CH_NUL, is_last: 1'b1, error: 1'b1});
            return;
        end
        secs = millis / 64'd1000;
        ms   = millis % 64'd1000;
        days = secs / 64'd86400;
        sod  = secs % 64'd86400;
        // eras of 400 years counted from 0000-03-01
        z     = days + 64'd719468;
        era   = z / 64'd146097;
        doe   = z - era * 64'd146097;
        yoe   = (doe - doe / 64'd1460 + doe / 64'd36524 - doe / 64'd146096) / 64'd365;
        year  = yoe + era * 64'd400;
        doy   = doe - (64'd365 * yoe + yoe / 64'd4 - yoe / 64'd100);
        mp    = (64'd5 * doy + 64'd2) / 64'd153;
        day   = doy - (64'd153 * mp + 64'd2) / 64'd5 + 64'd1;
        month = (mp < 64'd10) ? mp + 64'd3 : mp - 64'd9;
        if (month <= 64'd2) begin
            year = year + 64'd1;
        end
        // five-digit years are rejected
        if (year > LAST_YEAR) begin
            add_expected('{char_code: CH_NUL, is_last: 1'b1, error: 1'b1});
            return;
        end
        // YYYY-MM-DDTHH:MM:SS.mmmZ
        text[0]  = dec_digit(year, 64'd1000);
        text[1]  = dec_digit(year, 64'd100);
        text[2]  = dec_digit(year, 64'd10);
        text[3]  = dec_digit(year, 64'd1);
        text[4]  = CH_DASH;
        text[5]  = dec_digit(month, 64'd10);
        text[6]  = dec_digit(month, 64'd1);
        text[7]  = CH_DASH;
        text[8]  = dec_digit(day, 64'd10);
        text[9]  = dec_digit(day, 64'd1);
        text[10] = CH_T;
        text[11] = dec_digit(sod / 64'd3600, 64'd10);
        text[12] = dec_digit(sod / 64'd3600, 64'd1);
        text[13] = CH_COLON;
        text[14] = dec_digit((sod / 64'd60) % 64'd60, 64'd10);
        text[15] = dec_digit((sod / 64'd60) % 64'd60, 64'd1);
        text[16] = CH_COLON;
        text[17] = dec_digit(sod % 64'd60, 64'd10);
        text[18] = dec_digit(sod % 64'd60, 64'd1);
        text[19] = CH_DOT;
        text[20] = dec_digit(ms, 64'd100);
        text[21] = dec_digit(ms, 64'd10);
        text[22] = dec_digit(ms, 64'd1);
        text[23] = CH_Z;
        for (int k = 0; k < TEXT_LEN; k++) begin
            add_expected('{char_code: text[k], is_last: (k == TEXT_LEN - 1),
                           error: 1'b0});
        end
    endtask

    // watch both channels, predict on each request, compare each character
    always @(posedge i_clk) begin : watch
        text_char_t head;
        if (i_rst_n) begin
            if (i_req_valid && !i_req_stall) begin
                predict_timestamp_text(i_req_millis);
            end
            if (i_text_valid && !i_text_stall) begin
                if (expected_text.size() == 0) begin
                    $error("unexpected text character %h", i_char_code);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    head = expected_text.pop_front();
                    if (i_char_code !== head.char_code) begin
                        $error("char_code expected %h got %h", head.char_code, i_char_code);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_is_last !== head.is_last) begin
                        $error("is_last expected %b got %b", head.is_last, i_is_last);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_error !== head.error) begin
                        $error("error expected %b got %b", head.error, i_error);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_outstanding <= expected_text.size();
    end

endmodule

@@ test/tb.sv @@
// testbench top: request stimulus, idle patterns and verdict for the ISO 8601 text converter
`timescale 1ns / 100ps

module tb;
    import em2iso_pkg::*;

    localparam logic [MILLIS_W-1:0] FIRST_REJECTED = 64'd253402300800000;
    localparam int                  LAST_DAY       = 2932896;
    localparam longint unsigned     MS_PER_DAY     = 64'd86400000;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic [MILLIS_W-1:0] i_epoch_millis = '0;
    logic                i_stall        = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [CHAR_W-1:0]   o_char_code;
    logic                o_is_last;
    logic                o_error;

    int fail_count;
    int outstanding;
    int tx_idle_pct = 20;
    int rx_idle_pct = 63;

    epoch_millis_to_iso8601_text u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_epoch_millis (i_epoch_millis),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_char_code    (o_char_code),
        .o_is_last      (o_is_last),
        .o_error        (o_error)
    );

    epoch_millis_to_iso8601_text_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_req_millis  (i_epoch_millis),
        .i_text_valid  (o_valid),
        .i_text_stall  (i_stall),
        .i_char_code   (o_char_code),
        .i_is_last     (o_is_last),
        .i_error       (o_error),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // text side back-pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // hard stop
    initial begin
        #2000000;
        $display("epoch_millis_to_iso8601_text verification failed");
        $finish;
    end

    // one request, with random idle cycles ahead of it
    task automatic send_epoch_millis(input logic [MILLIS_W-1:0] millis);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid        <= 1'b0;
            i_epoch_millis <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_epoch_millis <= millis;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    // hold off requests until every character has come out
    task automatic drain_text;
        i_valid <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
    endtask

    // mostly in-range instants, plus negatives and five-digit years
    function automatic logic [MILLIS_W-1:0] random_epoch_millis();
        logic [MILLIS_W-1:0] r;
        int                  pick;
        r    = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 12) begin
            r[MILLIS_W-1] = 1'b1;
        end else if (pick < 18) begin
            r = FIRST_REJECTED + 64'($urandom_range(0, 100000));
        end else if (pick < 26) begin
            r[MILLIS_W-1] = 1'b0;
            r = r | (64'd1 << $urandom_range(48, 62));
        end else if (pick < 50) begin
            r = r % FIRST_REJECTED;
        end else if (pick < 75) begin
            // either side of midnight
            r = 64'($urandom_range(0, LAST_DAY)) * MS_PER_DAY;
            if ($urandom_range(1)) begin
                r = r + 64'($urandom_range(0, 1999));
            end else begin
                r = r + MS_PER_DAY - 64'd1 - 64'($urandom_range(0, 1999));
            end
        end else if (pick < 90) begin
            r = {20'd0, 12'($urandom_range(0, 4095)), $urandom};
        end else begin
            r = 64'($urandom_range(0, 100000000));
        end
        return r;
    endfunction

    // stimulus and verdict
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // field extremes, leap days, year limits
        send_epoch_millis(64'd0);
        send_epoch_millis(64'd1);
        send_epoch_millis(64'd999);
        send_epoch_millis(64'd1000);
        send_epoch_millis(64'd86399999);
        send_epoch_millis(64'd86400000);
        send_epoch_millis(64'd68169600000);
        send_epoch_millis(64'd946684799999);
        send_epoch_millis(64'd946684800000);
        send_epoch_millis(64'd951782400000);
        send_epoch_millis(64'd951868799999);
        send_epoch_millis(64'd4107542399999);
        send_epoch_millis(64'd4107542400000);
        send_epoch_millis(64'd1234567890123);
        send_epoch_millis(64'h0000_AAAA_AAAA_AAAA);
        send_epoch_millis(FIRST_REJECTED - 64'd1);
        send_epoch_millis(FIRST_REJECTED);
        send_epoch_millis(64'h5555_5555_5555_5555);
        send_epoch_millis(64'h7FFF_FFFF_FFFF_FFFF);
        send_epoch_millis(64'h8000_0000_0000_0000);
        send_epoch_millis(64'hFFFF_FFFF_FFFF_FFFF);
        drain_text();

        // sender idles less than receiver
        repeat (107) send_epoch_millis(random_epoch_millis());

        // receiver idles less than sender
        tx_idle_pct = 63;
        rx_idle_pct <= 20;
        repeat (107) send_epoch_millis(random_epoch_millis());

        // full rate both sides
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        repeat (106) send_epoch_millis(random_epoch_millis());

        // let the last text drain, then a few more cycles
        drain_text();
        repeat (40) @(posedge i_clk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("epoch_millis_to_iso8601_text verification clean");
        end else begin
            $display("epoch_millis_to_iso8601_text verification failed");
        end
        $finish;
    end

endmodule
